### hdl/adjacency_list_builder_macros.svh
// ---------------------------------------------------------------------------
// Adjacency list builder assertion macros
// Shared concurrent assertion forms, clocked on aclk, idle in reset.
// ---------------------------------------------------------------------------
`ifndef ADJACENCY_LIST_BUILDER_MACROS_SVH
`define ADJACENCY_LIST_BUILDER_MACROS_SVH

// Same-cycle implication.
`define ALB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/alb_pkg.sv
// ---------------------------------------------------------------------------
// Adjacency list builder package
// Field widths, mode codes, defaults and the result record.
// ---------------------------------------------------------------------------
package alb_pkg;

    localparam int SRC_W      = 7;
    localparam int DST_W      = 7;
    localparam int WT_W       = 16;
    localparam int NODE_CNT_W = 7;
    localparam int RES_W      = SRC_W + DST_W + WT_W;
    localparam int TDATA_W    = ((RES_W + 7) / 8) * 8;

    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = 7'd64;

    localparam int DEFAULT_MAX_NODES = 64;
    localparam int DEFAULT_MAX_EDGES = 64;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_DUMP = 1'b1;

    // One stored edge, source in the lowest bits.
    typedef struct packed {
        logic signed [WT_W-1:0] weight;
        logic [DST_W-1:0]       dest;
        logic [SRC_W-1:0]       source;
    } result_t;

endpackage

### hdl/alb_ram.sv
// ---------------------------------------------------------------------------
// Generic single-clock RAM
// One write port, one read port, read data registered on read enable.
// ---------------------------------------------------------------------------
module alb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/adjacency_list_builder.sv
// ---------------------------------------------------------------------------
// Adjacency list builder
// Forward-star edge store: adds link an edge in front of its source node's
// list, a dump walks all lists by ascending node, newest edge first.
// ---------------------------------------------------------------------------
//  Channel   Ports             Direction  Contents
//  input     s_t*              in         tuser: mode; tdata: source, dest, weight
//  result    m_t*              out        tdata: source, dest, weight; tlast: last edge
//  config    cfg_*             in         node_count (7 bits)
//
//  An add reads the head entry, then writes the head entry and the edge record; an
//  ignored add writes nothing. A dump is accepted, then reads the head entry of each
//  scanned node and the record of each edge in turn from the registered head and edge
//  memories, and releases the final result when any edge was found. A full result
//  register stalls the walk.
//  Reset clears the head valid bits at once; no clearing pass is needed.
//  s_tready is high only while no add or dump is in progress.
// ---------------------------------------------------------------------------
module adjacency_list_builder
    import alb_pkg::*;
#(
    parameter int MAX_NODES = DEFAULT_MAX_NODES,
    parameter int MAX_EDGES = DEFAULT_MAX_EDGES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input transaction
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // source_node, dest_node, weight, zero pad
    input  logic                  s_tuser,   // mode
    // result transaction
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // out_source, out_dest, out_weight, zero pad
    output logic                  m_tlast,   // last_of_dump
    // configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [NODE_CNT_W-1:0] cfg_data   // node_count
);

    // Node and edge index widths
    localparam int NAW = $clog2(MAX_NODES);      // head memory address
    localparam int NCW = $clog2(MAX_NODES + 1);  // node counter, holds MAX_NODES
    localparam int EAW = $clog2(MAX_EDGES);      // edge memory address
    localparam int LW  = $clog2(MAX_EDGES + 1);  // link: 0 = none, else slot + 1
    localparam int EDW = LW + RES_W;             // edge record: next link and fields

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_HEAD,
        ST_EDGE,
        ST_FLUSH
    } state_t;

    state_t                  state_reg;
    logic [NODE_CNT_W-1:0]   node_count_reg;
    logic [LW-1:0]           edge_count_reg;
    logic [MAX_NODES-1:0]    head_valid_reg;
    logic                    head_hit_reg;
    logic [NCW-1:0]          node_reg;
    logic [NCW-1:0]          limit_reg;
    logic [NAW-1:0]          add_addr_reg;
    result_t                 add_edge_reg;
    logic                    pend_valid_reg;
    result_t                 pend_reg;
    logic                    m_valid_reg;
    logic                    m_last_reg;
    result_t                 m_res_reg;

    logic [NCW-1:0]          scan_limit;
    logic [NCW-1:0]          node_inc;
    logic                    node_last;
    logic                    add_ok;
    logic                    in_fire;
    logic                    out_free;
    logic                    can_emit;
    logic                    out_load;
    result_t                 in_edge;

    logic                    head_rd_en;
    logic [NAW-1:0]          head_rd_addr;
    logic [LW-1:0]           head_rd_data;
    logic [LW-1:0]           head_link;
    logic                    head_wr_en;
    logic [LW-1:0]           head_wr_data;

    logic                    edge_rd_en;
    logic [EAW-1:0]          edge_rd_addr;
    logic [EDW-1:0]          edge_rd_data;
    logic [LW-1:0]           edge_link;
    result_t                 edge_res;
    logic                    edge_wr_en;
    logic [EDW-1:0]          edge_wr_data;

    // Unpack the input transaction
    assign in_edge.source = s_tdata[SRC_W-1:0];
    assign in_edge.dest   = s_tdata[SRC_W +: DST_W];
    assign in_edge.weight = s_tdata[SRC_W + DST_W +: WT_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = TDATA_W'(m_res_reg);

    // Nodes scanned: min(node_count, MAX_NODES)
    assign scan_limit = (32'(node_count_reg) < 32'(MAX_NODES))
                      ? NCW'(node_count_reg) : NCW'(MAX_NODES);

    // Drop adds to a full store or to a source outside 1..limit
    assign add_ok = (32'(edge_count_reg) < 32'(MAX_EDGES))
                 && (in_edge.source != '0)
                 && (32'(in_edge.source) <= 32'(scan_limit));

    assign node_inc  = node_reg + NCW'(1);
    assign node_last = (node_inc == limit_reg);

    // An entry never written since reset reads as an empty list
    assign head_link = head_hit_reg ? head_rd_data : '0;
    assign edge_link = edge_rd_data[EDW-1 -: LW];
    assign edge_res  = result_t'(edge_rd_data[RES_W-1:0]);

    assign out_free = !m_valid_reg || m_tready;
    assign can_emit = !pend_valid_reg || out_free;

    // Load the result register from the held-back edge
    assign out_load = ((state_reg == ST_EDGE) && can_emit && pend_valid_reg)
                   || ((state_reg == ST_FLUSH) && out_free);

    // Memory read and write requests
    always_comb begin
        head_rd_en   = 1'b0;
        head_rd_addr = '0;
        edge_rd_en   = 1'b0;
        edge_rd_addr = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_tuser == MODE_ADD) && add_ok) begin
                    head_rd_en   = 1'b1;
                    head_rd_addr = NAW'(in_edge.source - SRC_W'(1));
                end else if (in_fire && (s_tuser == MODE_DUMP) && (scan_limit != '0)) begin
                    head_rd_en = 1'b1;
                end
            end
            ST_HEAD: begin
                if (head_link != '0) begin
                    edge_rd_en   = 1'b1;
                    edge_rd_addr = EAW'(head_link - LW'(1));
                end else if (!node_last) begin
                    head_rd_en   = 1'b1;
                    head_rd_addr = NAW'(node_inc);
                end
            end
            ST_EDGE: begin
                if (can_emit) begin
                    if (edge_link != '0) begin
                        edge_rd_en   = 1'b1;
                        edge_rd_addr = EAW'(edge_link - LW'(1));
                    end else if (!node_last) begin
                        head_rd_en   = 1'b1;
                        head_rd_addr = NAW'(node_inc);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Link the new edge in front of the old head
    assign head_wr_en   = (state_reg == ST_ADD);
    assign head_wr_data = edge_count_reg + LW'(1);
    assign edge_wr_en   = (state_reg == ST_ADD);
    assign edge_wr_data = {head_link, add_edge_reg};

    alb_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_NODES)
    ) u_head_ram (
        .aclk    (aclk),
        .wr_en   (head_wr_en),
        .wr_addr (add_addr_reg),
        .wr_data (head_wr_data),
        .rd_en   (head_rd_en),
        .rd_addr (head_rd_addr),
        .rd_data (head_rd_data)
    );

    alb_ram #(
        .WIDTH (EDW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_count_reg[EAW-1:0]),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_CNT_RESET;
            edge_count_reg <= '0;
            head_valid_reg <= '0;
            head_hit_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end

            // Capture whether the head entry read this cycle was ever written
            if (head_rd_en) begin
                head_hit_reg <= head_valid_reg[head_rd_addr];
            end

            // Load a result, or drop it once the transaction completes
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_tuser == MODE_ADD) begin
                            if (add_ok) begin
                                add_addr_reg <= NAW'(in_edge.source - SRC_W'(1));
                                add_edge_reg <= in_edge;
                                state_reg    <= ST_ADD;
                            end
                        end else if (scan_limit != '0) begin
                            node_reg  <= '0;
                            limit_reg <= scan_limit;
                            state_reg <= ST_HEAD;
                        end
                    end
                end
                ST_ADD: begin
                    head_valid_reg[add_addr_reg] <= 1'b1;
                    edge_count_reg               <= edge_count_reg + LW'(1);
                    state_reg                    <= ST_IDLE;
                end
                ST_HEAD: begin
                    if (head_link != '0) begin
                        state_reg <= ST_EDGE;
                    end else if (node_last) begin
                        state_reg <= pend_valid_reg ? ST_FLUSH : ST_IDLE;
                    end else begin
                        node_reg <= node_inc;
                    end
                end
                ST_EDGE: begin
                    if (can_emit) begin
                        // Hold one edge back so the final one can carry tlast
                        if (pend_valid_reg) begin
                            m_res_reg  <= pend_reg;
                            m_last_reg <= 1'b0;
                        end
                        pend_reg       <= edge_res;
                        pend_valid_reg <= 1'b1;
                        if (edge_link == '0) begin
                            if (node_last) begin
                                state_reg <= ST_FLUSH;
                            end else begin
                                node_reg  <= node_inc;
                                state_reg <= ST_HEAD;
                            end
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        m_res_reg      <= pend_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/alb_checker.sv
// ---------------------------------------------------------------------------
// Adjacency list builder port checker
// Watches the top-level ports and is bound to every instance.
// ---------------------------------------------------------------------------
`include "adjacency_list_builder_macros.svh"

module alb_checker
    import alb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [TDATA_W-1:0]    s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic                  m_tlast,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [NODE_CNT_W-1:0] cfg_data
);

    // A stalled result holds
    `ALB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // An add never produces a result
    `ALB_ASSERT_NEXT(a_add_silent, s_tvalid && s_tready && (s_tuser == MODE_ADD) && !m_tvalid, !m_tvalid, "result after an add")

    // Every emitted edge has a source of at least one
    `ALB_ASSERT_NOW(a_src_nonzero, m_tvalid, m_tdata[SRC_W-1:0] != '0, "edge with source zero")

    // No new transaction is taken while a dump still has edges to give
    `ALB_ASSERT_NOW(a_busy_in_dump, m_tvalid && !m_tlast, !s_tready, "input accepted mid dump")

endmodule

bind adjacency_list_builder alb_checker u_alb_checker (.*);
